// ===== sv/gpdz_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamepad deadzone package
// Shared command codes, status bundle and fixed constants of the conditioner.
// ----------------------------------------------------------------------------
package gpdz_pkg;

  // Width of the deadzone register and of the conditioned trigger outputs.
  localparam int unsigned DzW   = 15;
  localparam int unsigned TrigW = 15;

  // Largest deadzone accepted by the register (0.95 in Q0.15).
  localparam logic [DzW-1:0]   DZ_MAX   = 15'd31130;
  // Full-scale trigger output.
  localparam logic [TrigW-1:0] TRIG_MAX = 15'h7FFF;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_X,
    CMD_MUL_Y,
    CMD_SUM_DZ,
    CMD_SQRT_GO,
    CMD_STICK_ZERO,
    CMD_RAMP_GO,
    CMD_RAMP_TAKE,
    CMD_SCL_X,
    CMD_DIV_X_GO,
    CMD_AXIS_X_TAKE,
    CMD_SCL_Y,
    CMD_DIV_Y_GO,
    CMD_AXIS_Y_TAKE,
    CMD_TRIG_CHK,
    CMD_TRIG_ZERO,
    CMD_TRIG_GO,
    CMD_TRIG_TAKE,
    CMD_FINISH
  } cmd_e;

  // Command bundle: operation plus which stick or trigger it applies to.
  typedef struct packed {
    cmd_e op;
    logic sel;
  } cmd_t;

  // Status bundle returned by the datapath.
  typedef struct packed {
    logic gp;
    logic dead;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/gamepad_radial_deadzone_conditioner.sv =====
// ----------------------------------------------------------------------------
// Gamepad radial deadzone conditioner
// Applies a scaled radial deadzone to both sticks, remaps and ramps both
// triggers, and reports button edges for each gamepad poll.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Contents
//  --------  ----------------------  -----------------------------------------
//  config    cfg_we_i                deadzone radius, Q0.15, clamped to 0.95
//  input     in_valid_i / in_stall_o one poll: flag, four axes, two triggers,
//                                    button bitmap
//  output    out_valid_o/out_stall_i conditioned axes, triggers, button
//                                    state and edges, valid-pad echo
//
// One poll is worked on at a time. Each stick takes a multiply-accumulate
// of its squared length, an AxisBits-bit square root and three divisions
// of DivW quotient bits (DivW = max(2*AxisBits-1, AxisBits+14)); each trigger
// takes one division. The shared bit-serial divider sets the pace; a
// transaction is shorter when sticks or triggers sit inside the deadzone,
// and a non-gamepad poll skips the stick and trigger work.
// Reset clears the deadzone, the stored buttons and all handshake state.
// A finished result waits in the output register while the next poll is
// accepted and worked on; only the final copy waits for the output slot.
//
module gamepad_radial_deadzone_conditioner #(
  parameter int unsigned BUTTON_COUNT = 15,
  parameter int unsigned AXIS_BITS    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [gpdz_pkg::DzW-1:0]    cfg_data_i,
  // Input transactions.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        is_gamepad_i,
  input  logic signed [AXIS_BITS-1:0] left_x_raw_i,
  input  logic signed [AXIS_BITS-1:0] left_y_raw_i,
  input  logic signed [AXIS_BITS-1:0] right_x_raw_i,
  input  logic signed [AXIS_BITS-1:0] right_y_raw_i,
  input  logic signed [AXIS_BITS-1:0] left_trigger_raw_i,
  input  logic signed [AXIS_BITS-1:0] right_trigger_raw_i,
  input  logic [BUTTON_COUNT-1:0]     buttons_raw_i,
  // Output transactions.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [AXIS_BITS-1:0] left_x_o,
  output logic signed [AXIS_BITS-1:0] left_y_o,
  output logic signed [AXIS_BITS-1:0] right_x_o,
  output logic signed [AXIS_BITS-1:0] right_y_o,
  output logic [gpdz_pkg::TrigW-1:0]  left_trigger_o,
  output logic [gpdz_pkg::TrigW-1:0]  right_trigger_o,
  output logic [BUTTON_COUNT-1:0]     buttons_down_o,
  output logic [BUTTON_COUNT-1:0]     buttons_pressed_o,
  output logic [BUTTON_COUNT-1:0]     buttons_released_o,
  output logic                        gamepad_valid_o
);

  // The controller issues one datapath command per cycle and advances on
  // the completion flags of the square root and divider units.
  gpdz_pkg::cmd_t  cmd;
  gpdz_pkg::stat_t stat;

  gpdz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gpdz_datapath #(
    .ButtonCount (BUTTON_COUNT),
    .AxisBits    (AXIS_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i),
    .is_gamepad_i        (is_gamepad_i),
    .left_x_raw_i        (left_x_raw_i),
    .left_y_raw_i        (left_y_raw_i),
    .right_x_raw_i       (right_x_raw_i),
    .right_y_raw_i       (right_y_raw_i),
    .left_trigger_raw_i  (left_trigger_raw_i),
    .right_trigger_raw_i (right_trigger_raw_i),
    .buttons_raw_i       (buttons_raw_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .left_x_o            (left_x_o),
    .left_y_o            (left_y_o),
    .right_x_o           (right_x_o),
    .right_y_o           (right_y_o),
    .left_trigger_o      (left_trigger_o),
    .right_trigger_o     (right_trigger_o),
    .buttons_down_o      (buttons_down_o),
    .buttons_pressed_o   (buttons_pressed_o),
    .buttons_released_o  (buttons_released_o),
    .gamepad_valid_o     (gamepad_valid_o)
  );

endmodule

// ===== sv/gpdz_div.sv =====
// ----------------------------------------------------------------------------
// Gamepad deadzone divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpdz_div #(
  parameter int unsigned NumW = 31,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o,
  output logic            done_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = CntW'(NumW);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
      rem_d  = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_d  = {quo_q[NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== sv/gpdz_sqrt.sv =====
// ----------------------------------------------------------------------------
// Gamepad deadzone square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module gpdz_sqrt #(
  parameter int unsigned RootW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic [RootW-1:0]   root_o,
  output logic               done_o
);

  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [2*RootW-1:0] rad_q, rad_d;
  logic [RootW:0]     rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [RootW+2:0]   rem_t;
  logic [RootW+2:0]   trial;
  logic [RootW+2:0]   diff;
  logic               ge;

  assign rem_t = {rem_q, rad_q[2*RootW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = rem_t >= trial;
  assign diff  = rem_t - trial;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      cnt_d  = CntW'(RootW);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
      rad_d  = {rad_q[2*RootW-3:0], 2'b00};
      rem_d  = ge ? diff[RootW:0] : rem_t[RootW:0];
      root_d = {root_q[RootW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== sv/gpdz_datapath.sv =====
// ----------------------------------------------------------------------------
// Gamepad deadzone datapath
// Sample registers, shared multiplier, square root and divider, result
// registers and the output register stage.
// ----------------------------------------------------------------------------
module gpdz_datapath #(
  parameter int unsigned ButtonCount = 15,
  parameter int unsigned AxisBits    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gpdz_pkg::cmd_t                cmd_i,
  output gpdz_pkg::stat_t               stat_o,
  input  logic                          cfg_we_i,
  input  logic [gpdz_pkg::DzW-1:0]      cfg_data_i,
  input  logic                          is_gamepad_i,
  input  logic signed [AxisBits-1:0]    left_x_raw_i,
  input  logic signed [AxisBits-1:0]    left_y_raw_i,
  input  logic signed [AxisBits-1:0]    right_x_raw_i,
  input  logic signed [AxisBits-1:0]    right_y_raw_i,
  input  logic signed [AxisBits-1:0]    left_trigger_raw_i,
  input  logic signed [AxisBits-1:0]    right_trigger_raw_i,
  input  logic [ButtonCount-1:0]        buttons_raw_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [AxisBits-1:0]    left_x_o,
  output logic signed [AxisBits-1:0]    left_y_o,
  output logic signed [AxisBits-1:0]    right_x_o,
  output logic signed [AxisBits-1:0]    right_y_o,
  output logic [gpdz_pkg::TrigW-1:0]    left_trigger_o,
  output logic [gpdz_pkg::TrigW-1:0]    right_trigger_o,
  output logic [ButtonCount-1:0]        buttons_down_o,
  output logic [ButtonCount-1:0]        buttons_pressed_o,
  output logic [ButtonCount-1:0]        buttons_released_o,
  output logic                          gamepad_valid_o
);

  localparam int unsigned A     = AxisBits;
  localparam int unsigned F     = AxisBits - 1;
  localparam int unsigned P     = 2 * AxisBits;
  localparam int unsigned DivW  = (2 * AxisBits - 1 > AxisBits + 14) ?
                                  (2 * AxisBits - 1) : (AxisBits + 14);
  localparam logic [A-1:0] AXIS_ONE = {1'b1, {F{1'b0}}};
  localparam logic [A-1:0] AXIS_MAX = {1'b0, {F{1'b1}}};

  gpdz_pkg::cmd_e op;
  assign op = cmd_i.op;

  // Configuration and control registers.
  logic [gpdz_pkg::DzW-1:0] dz_q;
  logic                     dead_q, dead_d;
  logic                     gp_q;
  logic [ButtonCount-1:0]   prev_btn_q;
  logic                     out_valid_q;
  logic                     out_free;

  // Sample registers.
  logic signed [A-1:0]    lx_q, ly_q, rx_q, ry_q, lt_q, rt_q;
  logic [ButtonCount-1:0] btn_q;

  // Working registers.
  logic [P-1:0] mul_q;
  logic [P-1:0] acc_q;
  logic [A-1:0] ramp_q;

  // Per-item results.
  logic signed [A-1:0]           res_lx_q, res_ly_q, res_rx_q, res_ry_q;
  logic [gpdz_pkg::TrigW-1:0]    res_lt_q, res_rt_q;

  // Output register stage.
  logic signed [A-1:0]           o_lx_q, o_ly_q, o_rx_q, o_ry_q;
  logic [gpdz_pkg::TrigW-1:0]    o_lt_q, o_rt_q;
  logic [ButtonCount-1:0]        o_down_q, o_press_q, o_rel_q;
  logic                          o_gp_q;

  // Deadzone brought to axis scale: deadzone * 2^(F-15), truncated.
  logic [A+15:0] dz_full;
  logic [A-1:0]  dz;
  logic [A-1:0]  den_dz;
  assign dz_full = {1'b0, dz_q, {A{1'b0}}};
  assign dz      = dz_full[16 +: A];
  assign den_dz  = AXIS_ONE - dz;

  // Operand selection for the current stick or trigger.
  logic signed [A-1:0] cur_x, cur_y, cur_t;
  logic [A-1:0]        mag_x, mag_y;
  logic [A-1:0]        t_off;
  logic [A-1:0]        p_ext;
  assign cur_x = cmd_i.sel ? rx_q : lx_q;
  assign cur_y = cmd_i.sel ? ry_q : ly_q;
  assign cur_t = cmd_i.sel ? rt_q : lt_q;
  assign mag_x = cur_x[A-1] ? ($unsigned(~cur_x) + A'(1)) : $unsigned(cur_x);
  assign mag_y = cur_y[A-1] ? ($unsigned(~cur_y) + A'(1)) : $unsigned(cur_y);
  // Adding one full scale to the trigger only flips its sign bit.
  assign t_off = {~cur_t[A-1], cur_t[A-2:0]};
  assign p_ext = {1'b0, t_off[A-1:1]};

  // Shared multiplier.
  logic [A-1:0] mul_a, mul_b;
  logic         mul_en;
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (op)
      gpdz_pkg::CMD_MUL_X: begin
        mul_a = mag_x;
        mul_b = mag_x;
      end
      gpdz_pkg::CMD_MUL_Y: begin
        mul_a = mag_y;
        mul_b = mag_y;
      end
      gpdz_pkg::CMD_SUM_DZ: begin
        mul_a = dz;
        mul_b = dz;
      end
      gpdz_pkg::CMD_SCL_X: begin
        mul_a = mag_x;
        mul_b = ramp_q;
      end
      gpdz_pkg::CMD_SCL_Y: begin
        mul_a = mag_y;
        mul_b = ramp_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Square root of the squared stick length.
  logic         sqrt_start;
  logic [A-1:0] m;
  logic         sqrt_done;
  assign sqrt_start = (op == gpdz_pkg::CMD_SQRT_GO) && !(acc_q <= mul_q);

  gpdz_sqrt #(
    .RootW (A)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_q),
    .root_o  (m),
    .done_o  (sqrt_done)
  );

  // Shared divider.
  logic            div_start;
  logic [DivW-1:0] div_num;
  logic [A-1:0]    div_den;
  logic [DivW-1:0] div_quo;
  logic            div_done;
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = den_dz;
    unique case (op)
      gpdz_pkg::CMD_RAMP_GO: begin
        div_num = DivW'(m - dz) << F;
      end
      gpdz_pkg::CMD_DIV_X_GO, gpdz_pkg::CMD_DIV_Y_GO: begin
        // Round half away from zero by adding half the divisor.
        div_num = DivW'(mul_q) + DivW'(m >> 1);
        div_den = m;
      end
      gpdz_pkg::CMD_TRIG_GO: begin
        div_num = DivW'(p_ext - dz) << gpdz_pkg::TrigW;
      end
      default: div_start = 1'b0;
    endcase
  end

  gpdz_div #(
    .NumW (DivW),
    .DenW (A)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // Quotient post-processing.
  logic [A-1:0]               ramp_val;
  logic [A-1:0]               axis_val;
  logic [gpdz_pkg::TrigW-1:0] trig_val;
  logic                       neg;
  assign ramp_val = (div_quo > DivW'(AXIS_ONE)) ? AXIS_ONE : div_quo[A-1:0];
  assign neg      = (op == gpdz_pkg::CMD_AXIS_Y_TAKE) ? cur_y[A-1] : cur_x[A-1];
  always_comb begin
    if (!neg) begin
      axis_val = (div_quo >= DivW'(AXIS_ONE)) ? AXIS_MAX : div_quo[A-1:0];
    end else begin
      // The bit pattern of one full scale is also that of minus one.
      axis_val = (div_quo > DivW'(AXIS_ONE)) ? AXIS_ONE :
                 (~div_quo[A-1:0] + A'(1));
    end
  end
  assign trig_val = (div_quo >= DivW'(gpdz_pkg::TRIG_MAX)) ?
                    gpdz_pkg::TRIG_MAX : div_quo[gpdz_pkg::TrigW-1:0];

  always_comb begin
    dead_d = dead_q;
    if (op == gpdz_pkg::CMD_SQRT_GO) begin
      dead_d = acc_q <= mul_q;
    end else if (op == gpdz_pkg::CMD_TRIG_CHK) begin
      dead_d = p_ext <= dz;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q        <= '0;
      dead_q      <= 1'b0;
      gp_q        <= 1'b0;
      prev_btn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dz_q <= (cfg_data_i > gpdz_pkg::DZ_MAX) ? gpdz_pkg::DZ_MAX : cfg_data_i;
      end
      dead_q <= dead_d;
      if (op == gpdz_pkg::CMD_LOAD) begin
        gp_q <= is_gamepad_i;
      end
      if (op == gpdz_pkg::CMD_FINISH) begin
        prev_btn_q  <= gp_q ? btn_q : '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (op == gpdz_pkg::CMD_LOAD) begin
      lx_q  <= left_x_raw_i;
      ly_q  <= left_y_raw_i;
      rx_q  <= right_x_raw_i;
      ry_q  <= right_y_raw_i;
      lt_q  <= left_trigger_raw_i;
      rt_q  <= right_trigger_raw_i;
      btn_q <= buttons_raw_i;
    end
    if (mul_en) begin
      mul_q <= P'(mul_a) * P'(mul_b);
    end
    if (op == gpdz_pkg::CMD_MUL_Y) begin
      acc_q <= mul_q;
    end else if (op == gpdz_pkg::CMD_SUM_DZ) begin
      acc_q <= acc_q + mul_q;
    end
    if (op == gpdz_pkg::CMD_RAMP_TAKE) begin
      ramp_q <= ramp_val;
    end
    unique case (op)
      gpdz_pkg::CMD_STICK_ZERO: begin
        if (cmd_i.sel) begin
          res_rx_q <= '0;
          res_ry_q <= '0;
        end else begin
          res_lx_q <= '0;
          res_ly_q <= '0;
        end
      end
      gpdz_pkg::CMD_AXIS_X_TAKE: begin
        if (cmd_i.sel) res_rx_q <= $signed(axis_val);
        else res_lx_q <= $signed(axis_val);
      end
      gpdz_pkg::CMD_AXIS_Y_TAKE: begin
        if (cmd_i.sel) res_ry_q <= $signed(axis_val);
        else res_ly_q <= $signed(axis_val);
      end
      gpdz_pkg::CMD_TRIG_ZERO: begin
        if (cmd_i.sel) res_rt_q <= '0;
        else res_lt_q <= '0;
      end
      gpdz_pkg::CMD_TRIG_TAKE: begin
        if (cmd_i.sel) res_rt_q <= trig_val;
        else res_lt_q <= trig_val;
      end
      default: ;
    endcase
    if (op == gpdz_pkg::CMD_FINISH) begin
      if (gp_q) begin
        o_lx_q    <= res_lx_q;
        o_ly_q    <= res_ly_q;
        o_rx_q    <= res_rx_q;
        o_ry_q    <= res_ry_q;
        o_lt_q    <= res_lt_q;
        o_rt_q    <= res_rt_q;
        o_down_q  <= btn_q;
        o_press_q <= btn_q & ~prev_btn_q;
        o_rel_q   <= prev_btn_q & ~btn_q;
        o_gp_q    <= 1'b1;
      end else begin
        o_lx_q    <= '0;
        o_ly_q    <= '0;
        o_rx_q    <= '0;
        o_ry_q    <= '0;
        o_lt_q    <= '0;
        o_rt_q    <= '0;
        o_down_q  <= '0;
        o_press_q <= '0;
        o_rel_q   <= '0;
        o_gp_q    <= 1'b0;
      end
    end
  end

  assign stat_o.gp        = gp_q;
  assign stat_o.dead      = dead_q;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = out_free;

  assign out_valid_o        = out_valid_q;
  assign left_x_o           = o_lx_q;
  assign left_y_o           = o_ly_q;
  assign right_x_o          = o_rx_q;
  assign right_y_o          = o_ry_q;
  assign left_trigger_o     = o_lt_q;
  assign right_trigger_o    = o_rt_q;
  assign buttons_down_o     = o_down_q;
  assign buttons_pressed_o  = o_press_q;
  assign buttons_released_o = o_rel_q;
  assign gamepad_valid_o    = o_gp_q;

endmodule

// ===== sv/gpdz_ctrl.sv =====
// ----------------------------------------------------------------------------
// Gamepad deadzone controller
// Sequencer that walks both sticks and both triggers of a gamepad poll through the datapath.
// ----------------------------------------------------------------------------
module gpdz_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gpdz_pkg::stat_t stat_i,
  output gpdz_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_GPCK = 5'd1;
  localparam logic [4:0] S_MX   = 5'd2;
  localparam logic [4:0] S_MY   = 5'd3;
  localparam logic [4:0] S_SUM  = 5'd4;
  localparam logic [4:0] S_SQGO = 5'd5;
  localparam logic [4:0] S_SQW  = 5'd6;
  localparam logic [4:0] S_RW   = 5'd7;
  localparam logic [4:0] S_SX   = 5'd8;
  localparam logic [4:0] S_DXG  = 5'd9;
  localparam logic [4:0] S_DXW  = 5'd10;
  localparam logic [4:0] S_SY   = 5'd11;
  localparam logic [4:0] S_DYG  = 5'd12;
  localparam logic [4:0] S_DYW  = 5'd13;
  localparam logic [4:0] S_TC   = 5'd14;
  localparam logic [4:0] S_TG   = 5'd15;
  localparam logic [4:0] S_TW   = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;

  logic [4:0] state_q, state_d;
  logic       sel_q, sel_d;

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o.op   = gpdz_pkg::CMD_NONE;
    cmd_o.sel  = sel_q;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = gpdz_pkg::CMD_LOAD;
          sel_d    = 1'b0;
          state_d  = S_GPCK;
        end
      end
      S_GPCK: state_d = stat_i.gp ? S_MX : S_FIN;
      S_MX: begin
        cmd_o.op = gpdz_pkg::CMD_MUL_X;
        state_d  = S_MY;
      end
      S_MY: begin
        cmd_o.op = gpdz_pkg::CMD_MUL_Y;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = gpdz_pkg::CMD_SUM_DZ;
        state_d  = S_SQGO;
      end
      S_SQGO: begin
        cmd_o.op = gpdz_pkg::CMD_SQRT_GO;
        state_d  = S_SQW;
      end
      S_SQW: begin
        if (stat_i.dead) begin
          cmd_o.op = gpdz_pkg::CMD_STICK_ZERO;
          sel_d    = !sel_q;
          state_d  = sel_q ? S_TC : S_MX;
        end else if (stat_i.sqrt_done) begin
          cmd_o.op = gpdz_pkg::CMD_RAMP_GO;
          state_d  = S_RW;
        end
      end
      S_RW: begin
        if (stat_i.div_done) begin
          cmd_o.op = gpdz_pkg::CMD_RAMP_TAKE;
          state_d  = S_SX;
        end
      end
      S_SX: begin
        cmd_o.op = gpdz_pkg::CMD_SCL_X;
        state_d  = S_DXG;
      end
      S_DXG: begin
        cmd_o.op = gpdz_pkg::CMD_DIV_X_GO;
        state_d  = S_DXW;
      end
      S_DXW: begin
        if (stat_i.div_done) begin
          cmd_o.op = gpdz_pkg::CMD_AXIS_X_TAKE;
          state_d  = S_SY;
        end
      end
      S_SY: begin
        cmd_o.op = gpdz_pkg::CMD_SCL_Y;
        state_d  = S_DYG;
      end
      S_DYG: begin
        cmd_o.op = gpdz_pkg::CMD_DIV_Y_GO;
        state_d  = S_DYW;
      end
      S_DYW: begin
        if (stat_i.div_done) begin
          cmd_o.op = gpdz_pkg::CMD_AXIS_Y_TAKE;
          sel_d    = !sel_q;
          state_d  = sel_q ? S_TC : S_MX;
        end
      end
      S_TC: begin
        cmd_o.op = gpdz_pkg::CMD_TRIG_CHK;
        state_d  = S_TG;
      end
      S_TG: begin
        if (stat_i.dead) begin
          cmd_o.op = gpdz_pkg::CMD_TRIG_ZERO;
          sel_d    = !sel_q;
          state_d  = sel_q ? S_FIN : S_TC;
        end else begin
          cmd_o.op = gpdz_pkg::CMD_TRIG_GO;
          state_d  = S_TW;
        end
      end
      S_TW: begin
        if (stat_i.div_done) begin
          cmd_o.op = gpdz_pkg::CMD_TRIG_TAKE;
          sel_d    = !sel_q;
          state_d  = sel_q ? S_FIN : S_TC;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = gpdz_pkg::CMD_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule
